### rtl/core/timeout_timer_queue_top_macros.svh
// Assertion macros used by the timer queue top
`ifndef TIMEOUT_TIMER_QUEUE_TOP_MACROS_SVH
`define TIMEOUT_TIMER_QUEUE_TOP_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define TMQ_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// precondition followed by a check in the next cycle
`define TMQ_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/tmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmq_pkg
// Types, constants and helpers of the timeout timer queue.
// ----------------------------------------------------------------------------
package tmq_pkg;

    localparam int TIMER_SLOTS = 64;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int ID_W        = 8;
    localparam int TMO_W       = 24;
    localparam int NOW_W       = 32;
    localparam int DL_W        = 33;
    localparam int NEAR_W      = 25;

    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_CANCEL  = 2'd1;
    localparam logic [1:0] CMD_SERVICE = 2'd2;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;
    localparam logic [1:0] KIND_FULL    = 2'd3;

    localparam logic [NEAR_W-1:0] NEAREST_NONE = '1;
    localparam logic [NEAR_W-1:0] NEAREST_MAX  = NEAR_W'(24'hFFFFFF);

    typedef struct packed {
        logic              valid;
        logic [DL_W-1:0]   dl;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   owner;
    } tmq_entry_t;

    typedef struct packed {
        logic       ins;
        logic       del;
        logic       pop;
        tmq_entry_t key;
    } tmq_ctl_t;

    function automatic logic [NEAR_W-1:0] nearest_f(input tmq_entry_t e,
                                                    input logic [NOW_W-1:0] now);
        logic [DL_W-1:0] n33;
        logic [DL_W-1:0] d;
        begin
            n33 = {1'b0, now};
            d   = e.dl - n33;
            if (!e.valid) begin
                return NEAREST_NONE;
            end
            if (e.dl <= n33) begin
                return '0;
            end
            if (d > DL_W'(NEAREST_MAX)) begin
                return NEAREST_MAX;
            end
            return d[NEAR_W-1:0];
        end
    endfunction

endpackage

### rtl/core/tmq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmq_cell
// One cell of the sorted timer chain: insert, remove by owner, pop head.
// ----------------------------------------------------------------------------
module tmq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  tmq_pkg::tmq_ctl_t  ctl,
    input  tmq_pkg::tmq_entry_t prev_entry,
    input  logic               prev_less,
    input  tmq_pkg::tmq_entry_t next_entry,
    input  logic               del_in,
    output tmq_pkg::tmq_entry_t entry,
    output logic               less,
    output logic               del_out,
    output logic               match
);

    tmq_pkg::tmq_entry_t entry_reg, entry_next;

    assign less    = entry_reg.valid &&
                     ({entry_reg.dl, entry_reg.slot} < {ctl.key.dl, ctl.key.slot});
    assign match   = entry_reg.valid && (entry_reg.owner == ctl.key.owner);
    assign del_out = del_in | match;
    assign entry   = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins) begin
            if (!less) begin
                entry_next = prev_less ? ctl.key : prev_entry;
            end
        end else if (ctl.del) begin
            if (del_out) begin
                entry_next = next_entry;
            end
        end else if (ctl.pop) begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule

### rtl/core/timeout_timer_queue_top.sv
`timescale 1ns / 1ps
// Add steps through cancel, insert, response; cancel through cancel, response.
// Service: one expired timer per cycle while the result register drains.
// A new command is taken only in idle, once the last result is registered;
// output stalls hold the response and service states.
// The sorted cell chain takes one update per cycle.
// Reset: synchronous active-low aresetn empties the chain and slot map.
// ----------------------------------------------------------------------------
// timeout_timer_queue_top
// Deadline timer store kept as a sorted chain of cells, earliest at the head.
// ----------------------------------------------------------------------------
`include "timeout_timer_queue_top_macros.svh"

module timeout_timer_queue_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // request_id[7:0], timeout_ms[31:8], now_ms[63:32]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // expired_request[7:0], nearest_ms[32:8], zero pad
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);

    localparam int N  = tmq_pkg::TIMER_SLOTS;
    localparam int SW = tmq_pkg::SLOT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CANCEL = 3'd1;
    localparam logic [2:0] S_INS    = 3'd2;
    localparam logic [2:0] S_RESP   = 3'd3;
    localparam logic [2:0] S_SERV   = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic                       is_add_reg, is_add_next;
    logic [1:0]                 kind_reg, kind_next;
    logic [tmq_pkg::ID_W-1:0]   id_reg, id_next;
    logic [tmq_pkg::TMO_W-1:0]  tmo_reg, tmo_next;
    logic [tmq_pkg::NOW_W-1:0]  now_reg, now_next;
    logic [N-1:0]               used_reg, used_next;

    logic                       mvalid_reg, mvalid_next;
    logic [1:0]                 mkind_reg, mkind_next;
    logic [tmq_pkg::ID_W-1:0]   mreq_reg, mreq_next;
    logic [tmq_pkg::NEAR_W-1:0] mnear_reg, mnear_next;
    logic                       mlast_reg, mlast_next;

    tmq_pkg::tmq_ctl_t   ctl;
    tmq_pkg::tmq_entry_t ent [N];
    logic [N-1:0]        less_v, dout_v, match_v, valid_v;
    logic [SW-1:0]       freed_slot, free_slot;
    logic                have_free, ofree, head_due, second_due;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            tmq_pkg::tmq_entry_t pe, ne;
            logic pl, di;
            if (gi == 0) begin : g_first
                assign pe = '0;
                assign pl = 1'b1;
                assign di = 1'b0;
            end else begin : g_mid
                assign pe = ent[gi-1];
                assign pl = less_v[gi-1];
                assign di = dout_v[gi-1];
            end
            if (gi == N-1) begin : g_last
                assign ne = '0;
            end else begin : g_notlast
                assign ne = ent[gi+1];
            end
            tmq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .prev_entry (pe),
                .prev_less  (pl),
                .next_entry (ne),
                .del_in     (di),
                .entry      (ent[gi]),
                .less       (less_v[gi]),
                .del_out    (dout_v[gi]),
                .match      (match_v[gi])
            );
            assign valid_v[gi] = ent[gi].valid;
        end
    endgenerate

    always_comb begin
        freed_slot = '0;
        free_slot  = '0;
        for (int i = 0; i < N; i++) begin
            if (match_v[i]) begin
                freed_slot = freed_slot | ent[i].slot;
            end
        end
        for (int i = N - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_slot = SW'(i);
            end
        end
    end

    assign have_free  = ~&used_reg;
    assign ofree      = !mvalid_reg || m_tready;
    assign head_due   = ent[0].valid && (ent[0].dl <= {1'b0, now_reg});
    assign second_due = ent[1].valid && (ent[1].dl <= {1'b0, now_reg});

    always_comb begin
        state_next  = state_reg;
        is_add_next = is_add_reg;
        kind_next   = kind_reg;
        id_next     = id_reg;
        tmo_next    = tmo_reg;
        now_next    = now_reg;
        used_next   = used_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mkind_next  = mkind_reg;
        mreq_next   = mreq_reg;
        mnear_next  = mnear_reg;
        mlast_next  = mlast_reg;
        ctl         = '0;
        ctl.key.owner = id_reg;
        ctl.key.dl    = {1'b0, now_reg} + tmq_pkg::DL_W'(tmo_reg);
        ctl.key.slot  = free_slot;
        ctl.key.valid = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    id_next     = s_tdata[7:0];
                    tmo_next    = s_tdata[31:8];
                    now_next    = s_tdata[63:32];
                    kind_next   = tmq_pkg::KIND_ACK;
                    is_add_next = (s_tuser == tmq_pkg::CMD_ADD);
                    case (s_tuser)
                        tmq_pkg::CMD_ADD:     state_next = S_CANCEL;
                        tmq_pkg::CMD_CANCEL:  state_next = S_CANCEL;
                        tmq_pkg::CMD_SERVICE: state_next = S_SERV;
                        default:              state_next = S_RESP;
                    endcase
                end
            end
            S_CANCEL: begin
                ctl.del = 1'b1;
                if (|match_v) begin
                    used_next[freed_slot] = 1'b0;
                end
                state_next = is_add_reg ? S_INS : S_RESP;
            end
            S_INS: begin
                if (have_free) begin
                    ctl.ins              = 1'b1;
                    used_next[free_slot] = 1'b1;
                end else begin
                    kind_next = tmq_pkg::KIND_FULL;
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (ofree) begin
                    mvalid_next = 1'b1;
                    mkind_next  = kind_reg;
                    mreq_next   = '0;
                    mnear_next  = tmq_pkg::nearest_f(ent[0], now_reg);
                    mlast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SERV: begin
                if (ofree) begin
                    mvalid_next = 1'b1;
                    if (head_due) begin
                        ctl.pop                 = 1'b1;
                        used_next[ent[0].slot]  = 1'b0;
                        mkind_next = tmq_pkg::KIND_EXPIRED;
                        mreq_next  = ent[0].owner;
                        mnear_next = tmq_pkg::nearest_f(ent[1], now_reg);
                        mlast_next = !second_due;
                        if (!second_due) begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        mkind_next = tmq_pkg::KIND_NONE;
                        mreq_next  = '0;
                        mnear_next = tmq_pkg::nearest_f(ent[0], now_reg);
                        mlast_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        is_add_reg <= is_add_next;
        kind_reg   <= kind_next;
        id_reg     <= id_next;
        tmo_reg    <= tmo_next;
        now_reg    <= now_next;
        mkind_reg  <= mkind_next;
        mreq_reg   <= mreq_next;
        mnear_reg  <= mnear_next;
        mlast_reg  <= mlast_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {7'd0, mnear_reg, mreq_reg};
    assign m_tuser  = mkind_reg;
    assign m_tlast  = mlast_reg;

    // chain occupancy tracks the slot map
    `TMQ_ASSERT_ALWAYS(a_occupancy, aclk, aresetn, $countones(valid_v) == $countones(used_reg), "chain count differs from slot map")
    // each pop of an expired head frees exactly one slot
    `TMQ_ASSERT_NEXT(a_pop_frees, aclk, aresetn, ctl.pop, $countones(used_reg) + 1 == $countones($past(used_reg)), "pop did not free one slot")

endmodule

### tb/tb_timeout_timer_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timeout_timer_queue_top
// Drives add, cancel, service and other commands into the timer queue with
// random gaps and receiver stalls. A software copy of the timer store predicts
// the result transactions, compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_timeout_timer_queue_top;
    import tmq_pkg::*;

    localparam int N_SLOTS = 64;
    localparam int N_IDS   = 256;
    localparam int MAX_OUT = 64;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  id;
        logic [23:0] tmo;
        logic [31:0] now;
    } timer_cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  req;
        logic [24:0] near;
        logic        last;
    } timer_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    timeout_timer_queue_top u_top (.*);

    always #5 aclk = ~aclk;

    // timer store shadow
    bit          tv [N_SLOTS];
    logic [32:0] tdl [N_SLOTS];
    logic [7:0]  town [N_SLOTS];
    bit          has [N_IDS];
    int          oslot [N_IDS];

    timer_cmd_t pending_cmds[$];
    timer_res_t expected_results[$];
    int         errors = 0;
    bit         drive_done = 0;
    int         hold_cycles = 0;
    int         burst_hold = 0;
    logic [31:0] clock_ms = 0;

    function automatic int earliest_timer();
        int b;
        b = -1;
        for (int s = 0; s < N_SLOTS; s++)
            if (tv[s] && (b < 0 || tdl[s] < tdl[b])) b = s;
        return b;
    endfunction

    function automatic logic [24:0] ms_to_nearest(logic [31:0] now);
        int s;
        logic [32:0] d;
        s = earliest_timer();
        if (s < 0) return NEAREST_NONE;
        if (tdl[s] <= {1'b0, now}) return '0;
        d = tdl[s] - {1'b0, now};
        return (d > 33'hFFFFFF) ? NEAREST_MAX : d[24:0];
    endfunction

    function automatic void drop_owner(int id);
        if (has[id]) begin
            has[id] = 0;
            tv[oslot[id]] = 0;
        end
    endfunction

    task automatic predict_timer_results(timer_cmd_t c);
        timer_res_t r;
        int f, s, n;
        r = '0;
        n = 0;
        if (c.cmd == CMD_ADD) begin
            drop_owner(c.id);
            f = -1;
            for (s = 0; s < N_SLOTS; s++)
                if (!tv[s]) begin f = s; break; end
            if (f < 0) begin
                r.kind = KIND_FULL;
            end else begin
                tv[f] = 1;
                tdl[f] = {1'b0, c.now} + c.tmo;
                town[f] = c.id;
                has[c.id] = 1;
                oslot[c.id] = f;
                r.kind = KIND_ACK;
            end
        end else if (c.cmd == CMD_CANCEL) begin
            drop_owner(c.id);
            r.kind = KIND_ACK;
        end else if (c.cmd == CMD_SERVICE) begin
            while (n < MAX_OUT) begin
                s = earliest_timer();
                if (s < 0 || tdl[s] > {1'b0, c.now}) break;
                tv[s] = 0;
                if (has[town[s]] && oslot[town[s]] == s) has[town[s]] = 0;
                r = '0;
                r.kind = KIND_EXPIRED;
                r.req = town[s];
                r.near = ms_to_nearest(c.now);
                expected_results.push_back(r);
                n++;
            end
            if (n == 0) begin
                r.kind = KIND_NONE;
            end else begin
                expected_results[$].last = 1'b1;
                return;
            end
        end else begin
            r.kind = KIND_ACK;
        end
        r.near = ms_to_nearest(c.now);
        r.last = 1'b1;
        expected_results.push_back(r);
    endtask

    function automatic void queue_cmd(logic [1:0] cmd, logic [7:0] id, logic [23:0] tmo,
                                      logic [31:0] now);
        timer_cmd_t c;
        c.cmd = cmd;
        c.id = id;
        c.tmo = tmo;
        c.now = now;
        pending_cmds.push_back(c);
    endfunction

    // sender
    int  send_gap = 0;
    always @(posedge aclk) begin
        timer_cmd_t c;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_timer_results({s_tuser, s_tdata[7:0], s_tdata[31:8], s_tdata[63:32]});
                void'(pending_cmds.pop_front());
                send_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
                s_tvalid <= 1'b0;
                if (pending_cmds.size() == 0) drive_done <= 1;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds[0];
                s_tvalid <= 1'b1;
                s_tuser <= c.cmd;
                s_tdata <= {c.now, c.tmo, c.id};
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        timer_res_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result kind=%0d", m_tuser);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_tuser !== e.kind) begin
                        $error("kind exp %0d got %0d", e.kind, m_tuser); errors++;
                    end
                    if (m_tdata[7:0] !== e.req) begin
                        $error("expired_request exp %0d got %0d", e.req, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[32:8] !== e.near) begin
                        $error("nearest_ms exp %0d got %0d", $signed(e.near),
                               $signed(m_tdata[32:8]));
                        errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last exp %0d got %0d", e.last, m_tlast); errors++;
                    end
                end
            end
            if (burst_hold > 0) begin
                burst_hold <= burst_hold - 1;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                hold_cycles = $urandom_range(0, 2) == 0 ? $urandom_range(0, 16) : 0;
                m_tready <= (hold_cycles == 0);
            end else if (hold_cycles > 0) begin
                hold_cycles = hold_cycles - 1;
                m_tready <= (hold_cycles == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int id, k, dt;
        // directed
        queue_cmd(CMD_SERVICE, 0, 0, 0);
        queue_cmd(CMD_CANCEL, 5, 0, 0);
        queue_cmd(2'd3, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF);
        queue_cmd(CMD_ADD, 0, 0, 10);
        queue_cmd(CMD_ADD, 255, 24'hFFFFFF, 10);
        queue_cmd(CMD_ADD, 7, 100, 10);
        queue_cmd(CMD_ADD, 7, 50, 20);
        queue_cmd(CMD_ADD, 9, 50, 20);
        queue_cmd(CMD_CANCEL, 9, 0, 30);
        queue_cmd(CMD_SERVICE, 0, 0, 5);
        queue_cmd(CMD_SERVICE, 0, 0, 100);
        queue_cmd(CMD_ADD, 1, 24'hFFFFFF, 32'hFFFFFFFF);
        queue_cmd(CMD_ADD, 2, 10, 32'hFFFFFFFF);
        queue_cmd(CMD_CANCEL, 2, 0, 32'h0);
        queue_cmd(CMD_SERVICE, 0, 0, 32'hFFFFFFFF);
        // fill the store, overflow, then expire a large batch
        for (k = 0; k < 66; k++) queue_cmd(CMD_ADD, 8'(k + 10), 24'(k % 5), 1000);
        queue_cmd(CMD_ADD, 10, 3, 1000);
        queue_cmd(CMD_SERVICE, 0, 0, 2000);
        // random traffic with a mostly monotonic clock
        clock_ms = 3000;
        for (k = 0; k < 147; k++) begin
            dt = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 40);
            clock_ms = clock_ms + dt;
            id = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 31);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: queue_cmd(CMD_ADD, 8'(id),
                    $urandom_range(0, 5) == 0 ? 24'($urandom) : 24'($urandom_range(0, 80)),
                    clock_ms);
                4, 5: queue_cmd(CMD_CANCEL, 8'(id), 24'($urandom), clock_ms);
                6, 7, 8: queue_cmd(CMD_SERVICE, 8'(id), 24'($urandom), clock_ms);
                default: queue_cmd(2'($urandom_range(0, 3)), 8'(id), 24'($urandom), $urandom);
            endcase
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (200) @(posedge aclk);
        burst_hold <= 300;
        wait (drive_done && expected_results.size() == 0);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
